// ===== rtl/core/bebr_pkg.sv =====
`default_nettype none

package bebr_pkg;

    // Store geometry: every store is split into four byte lanes.
    localparam int LANES            = 4;
    localparam int RAM_BYTES_DEF    = 65536;
    localparam int REG_WINDOW_BYTES = 65536;
    localparam int REG_ROWS         = REG_WINDOW_BYTES / LANES;

    // Configuration register.
    localparam int CFG_W     = 17;
    localparam int CFG_RESET = 65536;

    // Access kinds and size codes.
    localparam logic       KIND_READ  = 1'b0;
    localparam logic       KIND_WRITE = 1'b1;
    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_HALF  = 2'd1;
    localparam logic [1:0] SIZE_WORD  = 2'd2;
    localparam logic [1:0] SIZE_NONE  = 2'd3;

    // Register window base (upper half of the address).
    localparam logic [15:0] REG_BASE_HI = 16'hCC00;

    // Register offsets with side effects on word accesses.
    localparam logic [15:0] OFF_VI_LINE     = 16'h2024;
    localparam logic [15:0] OFF_VI_LINE_ALT = 16'h202C;
    localparam logic [15:0] OFF_ICR         = 16'h3000;
    localparam logic [15:0] OFF_DI_STAT     = 16'h6434;
    localparam logic [15:0] OFF_SET_LSB_A   = 16'h6000;
    localparam logic [15:0] OFF_SET_LSB_B   = 16'h6024;
    localparam logic [15:0] OFF_CLR_BIT2    = 16'h6004;
    localparam logic [15:0] DMA_BASE        = 16'h6800;
    localparam logic [15:0] DMA_STRIDE      = 16'h0014;
    localparam logic [15:0] DMA_START_OFF   = 16'h000C;
    localparam int          DMA_CHANNELS    = 3;

    // Video line counter.
    localparam int VIDEO_LINES = 526;
    localparam int VIDEO_W     = 10;

    // Request and response payloads.
    typedef struct packed {
        logic        kind;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [31:0] write_data;
    } t_bus_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        bad_address;
    } t_bus_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/big_endian_bus_with_register_hle.sv =====
`default_nettype none

// Big-endian bus with a register window. Each request is one read or write of 8, 16 or 32 bits, or a no-op;
// the address is decoded into the cached (0x8000_0000), uncached (0xC000_0000) or physical RAM
// alias, each limited by ram_bytes_in_use, or into the 64 KiB register window at 0xCC00_0000.
// Unmatched addresses go to RAM byte 0 and set bad_address. Word reads and writes of a few
// registers have side effects (video line counter, status bits, DMA start bit, write-one-to-clear
// interrupt cause). Both stores live in four byte-lane synchronous memories and every request is a
// read, modify and write-back pass: a request goes through accept, memory read, modify and
// write-back, and response load, one at a time, so no forwarding is needed. After reset the block
// clears both stores, one row of four bytes per cycle, over max(RAM_BYTES, 65536) / 4 rows
// (16384 with the default size) before it takes the first request; configuration writes are taken
// at any time. RAM_BYTES must be a multiple of four.
module big_endian_bus_with_register_hle import bebr_pkg::*; #(
    parameter int RAM_BYTES = RAM_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    output logic                  o_req_ready,
    input  wire t_bus_req         i_req,
    output logic                  o_rsp_valid,
    input  wire logic             i_rsp_ready,
    output t_bus_rsp              o_rsp,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int RAM_AW   = $clog2(RAM_BYTES);
    localparam int RAM_RW   = RAM_AW - 2;
    localparam int RAM_ROWS = RAM_BYTES / LANES;
    localparam int REG_RW   = $clog2(REG_ROWS);
    localparam int SW       = (CFG_W > RAM_AW + 1) ? CFG_W : RAM_AW + 1;
    localparam int LIM_RST  = (RAM_BYTES < CFG_RESET) ? RAM_BYTES : CFG_RESET;
    localparam int CLR_ROWS = (RAM_ROWS > REG_ROWS) ? RAM_ROWS : REG_ROWS;
    localparam int CLR_W    = $clog2(CLR_ROWS);

    localparam logic [RAM_AW:0]      RAM_LIM   = (RAM_AW + 1)'(RAM_BYTES);
    localparam logic [CLR_W-1:0]     CLR_LAST  = CLR_W'(CLR_ROWS - 1);
    localparam logic [CLR_W:0]       CLR_RAM   = (CLR_W + 1)'(RAM_ROWS);
    localparam logic [CLR_W:0]       CLR_REG   = (CLR_W + 1)'(REG_ROWS);
    localparam logic [REG_RW-1:0]    VID_ROW   = OFF_VI_LINE[REG_RW+1:2];
    localparam logic [VIDEO_W-1:0]   VID_LAST  = VIDEO_W'(VIDEO_LINES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WRITE,
        S_PUSH
    } t_state;

    t_state              r_state;
    logic [CLR_W-1:0]    r_clr;
    logic [SW-1:0]       r_lim;
    logic [VIDEO_W-1:0]  r_video_line;
    logic                r_rsp_valid;
    t_bus_rsp            r_rsp;
    t_bus_rsp            r_pend;

    // Decoded request, held for the read and write-back cycles.
    logic                r_kind;
    logic [1:0]          r_size;
    logic [31:0]         r_wd;
    logic                r_nop;
    logic                r_sel_reg;
    logic                r_bad;
    logic [RAM_AW-1:0]   r_off_ram;
    logic [15:0]         r_off_reg;

    // Configuration: the size in effect is capped at the RAM size.
    logic [SW-1:0] n_lim;
    always_comb begin
        n_lim = SW'(i_cfg_data);
        if (n_lim > SW'(RAM_BYTES)) begin
            n_lim = SW'(RAM_BYTES);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Address decode in window priority order.
    logic [31:0]       lim32;
    logic              hit_cached;
    logic              hit_uncached;
    logic              hit_phys;
    logic              hit_reg;
    logic              hit_ram;
    logic              dec_nop;

    always_comb begin
        lim32        = 32'(r_lim);
        hit_cached   = i_req.address[31] && ({1'b0, i_req.address[30:0]} < lim32);
        hit_uncached = (i_req.address[31:30] == 2'b11)
                       && ({2'b00, i_req.address[29:0]} < lim32);
        hit_phys     = i_req.address < lim32;
        hit_reg      = i_req.address[31:16] == REG_BASE_HI;
        hit_ram      = hit_cached || hit_uncached || hit_phys;
        dec_nop      = i_req.access_size == SIZE_NONE;
    end

    // Lane rows: byte i of the access sits in lane (offset + i) mod 4.
    logic [RAM_AW:0]    ram_b   [LANES];
    logic [RAM_RW-1:0]  ram_row [LANES];
    logic [15:0]        reg_b   [LANES];
    logic [REG_RW-1:0]  reg_row [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            ram_b[l] = {1'b0, r_off_ram}
                       + (RAM_AW + 1)'(2'(2'(l) - r_off_ram[1:0]));
            if (ram_b[l] >= RAM_LIM) begin
                ram_b[l] = ram_b[l] - RAM_LIM;
            end
            ram_row[l] = ram_b[l][RAM_AW-1:2];
            reg_b[l]   = r_off_reg + 16'(2'(2'(l) - r_off_reg[1:0]));
            reg_row[l] = reg_b[l][REG_RW+1:2];
        end
    end

    // Memory read data gathered into big-endian byte order.
    logic [7:0]  ram_q [LANES];
    logic [7:0]  reg_q [LANES];
    logic [1:0]  off2;
    logic [31:0] word_ld;

    always_comb begin
        off2 = r_sel_reg ? r_off_reg[1:0] : r_off_ram[1:0];
        for (int i = 0; i < LANES; i++) begin
            word_ld[8*(3-i) +: 8] = r_sel_reg ? reg_q[2'(off2 + 2'(i))]
                                              : ram_q[2'(off2 + 2'(i))];
        end
    end

    // Modify step: read value, write value and byte mask, register side effects.
    logic                special;
    logic                dma_hit;
    logic [VIDEO_W-1:0]  vnext;
    logic [31:0]         rd_val;
    logic [31:0]         wv;
    logic [3:0]          act;
    logic                wr_on;
    logic                vid_wr;

    always_comb begin
        special = r_sel_reg && (r_size == SIZE_WORD);
        dma_hit = 1'b0;
        for (int ch = 0; ch < DMA_CHANNELS; ch++) begin
            if (r_off_reg == DMA_BASE + 16'(ch) * DMA_STRIDE + DMA_START_OFF) begin
                dma_hit = 1'b1;
            end
        end
        vnext  = (r_video_line == VID_LAST) ? '0 : r_video_line + VIDEO_W'(1);
        rd_val = '0;
        wv     = '0;
        act    = '0;
        wr_on  = 1'b0;
        vid_wr = 1'b0;
        if (!r_nop) begin
            unique case (r_size)
                SIZE_BYTE: act = 4'b0001;
                SIZE_HALF: act = 4'b0011;
                SIZE_WORD: act = 4'b1111;
                default:   act = 4'b0000;
            endcase
            if (r_kind == KIND_READ) begin
                unique case (r_size)
                    SIZE_BYTE: rd_val = {24'b0, word_ld[31:24]};
                    SIZE_HALF: rd_val = {16'b0, word_ld[31:16]};
                    default:   rd_val = word_ld;
                endcase
                if (special) begin
                    priority if (r_off_reg == OFF_VI_LINE || r_off_reg == OFF_VI_LINE_ALT) begin
                        vid_wr = 1'b1;
                        if (r_off_reg == OFF_VI_LINE) begin
                            rd_val = 32'(vnext);
                        end
                    end else if (r_off_reg == OFF_DI_STAT) begin
                        wv     = word_ld | 32'h8000_0000;
                        wr_on  = 1'b1;
                        rd_val = wv;
                    end else if (r_off_reg == OFF_SET_LSB_A || r_off_reg == OFF_SET_LSB_B) begin
                        wv     = word_ld | 32'h0000_0001;
                        wr_on  = 1'b1;
                        rd_val = wv;
                    end else if (r_off_reg == OFF_CLR_BIT2) begin
                        wv     = word_ld & ~32'h0000_0004;
                        wr_on  = 1'b1;
                        rd_val = wv;
                    end else begin
                        wr_on = 1'b0;
                    end
                end
            end else begin
                wr_on = 1'b1;
                unique case (r_size)
                    SIZE_BYTE: wv = {r_wd[7:0], 24'b0};
                    SIZE_HALF: wv = {r_wd[15:0], 16'b0};
                    default:   wv = r_wd;
                endcase
                if (special && dma_hit) begin
                    wv = r_wd & ~32'h0000_0001;
                end
                if (special && r_off_reg == OFF_ICR) begin
                    wv = word_ld & ~r_wd;
                end
            end
        end
    end

    // Write ports: clearing pass, video line update or the modified bytes.
    logic [LANES-1:0]   ram_we;
    logic [LANES-1:0]   reg_we;
    logic [RAM_RW-1:0]  ram_wrow [LANES];
    logic [REG_RW-1:0]  reg_wrow [LANES];
    logic [7:0]         wdata    [LANES];
    logic [31:0]        vid_word;
    logic [1:0]         bidx;

    always_comb begin
        vid_word = 32'(vnext);
        ram_we   = '0;
        reg_we   = '0;
        bidx     = '0;
        for (int l = 0; l < LANES; l++) begin
            ram_wrow[l] = ram_row[l];
            reg_wrow[l] = reg_row[l];
            wdata[l]    = '0;
            if (r_state == S_CLEAR) begin
                ram_wrow[l] = r_clr[RAM_RW-1:0];
                reg_wrow[l] = r_clr[REG_RW-1:0];
                ram_we[l]   = {1'b0, r_clr} < CLR_RAM;
                reg_we[l]   = {1'b0, r_clr} < CLR_REG;
            end else if (r_state == S_WRITE) begin
                if (vid_wr) begin
                    reg_wrow[l] = VID_ROW;
                    wdata[l]    = vid_word[8*(3-l) +: 8];
                    reg_we[l]   = 1'b1;
                end else begin
                    bidx      = 2'(2'(l) - off2);
                    wdata[l]  = wv[8*(3-bidx) +: 8];
                    ram_we[l] = wr_on && act[bidx] && !r_sel_reg;
                    reg_we[l] = wr_on && act[bidx] && r_sel_reg;
                end
            end
        end
    end

    bebr_mem #(
        .ROWS (RAM_ROWS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (r_state == S_READ),
        .i_rd_row  (ram_row),
        .o_rd_data (ram_q),
        .i_wr_en   (ram_we),
        .i_wr_row  (ram_wrow),
        .i_wr_data (wdata)
    );

    bebr_mem #(
        .ROWS (REG_ROWS)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rd_en   (r_state == S_READ),
        .i_rd_row  (reg_row),
        .o_rd_data (reg_q),
        .i_wr_en   (reg_we),
        .i_wr_row  (reg_wrow),
        .i_wr_data (wdata)
    );

    // Sequencer: clear, accept, read, modify and write back, deliver the response.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_lim        <= SW'(LIM_RST);
            r_video_line <= '0;
            r_rsp_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_lim <= n_lim;
            end
            // A response taken while a new one is loaded is handled in the delivery state.
            if (r_rsp_valid && i_rsp_ready && r_state != S_PUSH) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CLR_W'(1);
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_kind    <= i_req.kind;
                        r_size    <= i_req.access_size;
                        r_wd      <= i_req.write_data;
                        r_nop     <= dec_nop;
                        r_sel_reg <= !hit_ram && hit_reg;
                        r_bad     <= !hit_ram && !hit_reg && !dec_nop;
                        r_off_ram <= hit_ram ? i_req.address[RAM_AW-1:0] : '0;
                        r_off_reg <= i_req.address[15:0];
                        r_state   <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_pend.read_data   <= rd_val;
                    r_pend.bad_address <= r_bad;
                    if (vid_wr) begin
                        r_video_line <= vnext;
                    end
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!r_rsp_valid || i_rsp_ready) begin
                        r_rsp       <= r_pend;
                        r_rsp_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The video line counter never leaves its range.
    a_video_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_video_line <= VID_LAST)
        else $error("video line counter out of range");

    // Stores are only written while clearing or in the write-back cycle.
    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_READ || r_state == S_PUSH)
            |-> (ram_we == '0 && reg_we == '0))
        else $error("store written outside write-back");

    // An unmatched address never touches the register store.
    a_bad_no_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && r_bad) |-> (reg_we == '0))
        else $error("bad address wrote the register store");

    // A new response only appears after the write-back pass.
    a_rsp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> $past(r_state == S_PUSH))
        else $error("response raised outside delivery");

    // An accepted request always goes straight to the memory read.
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == S_READ))
        else $error("accepted request did not start a read");

endmodule

`default_nettype wire

// ===== rtl/core/bebr_mem.sv =====
`default_nettype none

module bebr_mem import bebr_pkg::*; #(
    parameter int ROWS = REG_ROWS,
    localparam int RW = $clog2(ROWS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [RW-1:0] i_rd_row  [LANES],
    output logic      [7:0]    o_rd_data [LANES],
    input  wire logic [LANES-1:0] i_wr_en,
    input  wire logic [RW-1:0] i_wr_row  [LANES],
    input  wire logic [7:0]    i_wr_data [LANES]
);

    // One synchronous byte memory per lane, each with its own row address.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [7:0] r_mem [ROWS];
        logic [7:0] r_q;

        always_ff @(posedge i_clk) begin
            if (i_wr_en[l]) begin
                r_mem[i_wr_row[l]] <= i_wr_data[l];
            end
            if (i_rd_en) begin
                r_q <= r_mem[i_rd_row[l]];
            end
        end

        assign o_rd_data[l] = r_q;
    end

endmodule

`default_nettype wire
